FILE: rtl/akd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

	localparam int NUM_KEYS    = 5;
	localparam int SAMPLE_BITS = 12;
	localparam int THR_W       = 13;
	localparam int MS_W        = 16;
	localparam int TIME_W      = 32;
	localparam int KEY_W       = 3;
	localparam int IDX_W       = 3;
	localparam int CFG_W       = 16;

	// Class code for "no key pressed"
	localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(NUM_KEYS + 1);

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_THR_ONE   = 3'd0,
		REG_THR_TWO   = 3'd1,
		REG_THR_THREE = 3'd2,
		REG_THR_FOUR  = 3'd3,
		REG_THR_FIVE  = 3'd4,
		REG_DEBOUNCE  = 3'd5,
		REG_REPEAT    = 3'd6
	} reg_idx_t;

	localparam logic [NUM_KEYS-1:0][THR_W-1:0] THR_RESET =
		{13'd3000, 13'd2000, 13'd1200, 13'd500, 13'd100};
	localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd100;
	localparam logic [MS_W-1:0] REPEAT_RESET   = 16'd500;

	typedef struct packed {
		logic [NUM_KEYS-1:0][THR_W-1:0] thr;
		logic [MS_W-1:0]                debounce_ms;
		logic [MS_W-1:0]                repeat_ms;
	} cfg_t;

	typedef struct packed {
		logic              pending_flag;
		logic [KEY_W-1:0]  pending_key;
		logic [KEY_W-1:0]  last_class;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/akd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module akd_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [akd_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [akd_pkg::CFG_W-1:0] cfg_data,
	output akd_pkg::cfg_t                  cfg
);
	import akd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr         <= THR_RESET;
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.repeat_ms   <= REPEAT_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THR_ONE:   cfg_q.thr[0]      <= cfg_data[THR_W-1:0];
				REG_THR_TWO:   cfg_q.thr[1]      <= cfg_data[THR_W-1:0];
				REG_THR_THREE: cfg_q.thr[2]      <= cfg_data[THR_W-1:0];
				REG_THR_FOUR:  cfg_q.thr[3]      <= cfg_data[THR_W-1:0];
				REG_THR_FIVE:  cfg_q.thr[4]      <= cfg_data[THR_W-1:0];
				REG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data[MS_W-1:0];
				REG_REPEAT:    cfg_q.repeat_ms   <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/akd_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module akd_classify (
	input  wire logic [akd_pkg::SAMPLE_BITS-1:0]                 sample,
	input  wire logic [akd_pkg::NUM_KEYS-1:0][akd_pkg::THR_W-1:0] thr,
	output logic      [akd_pkg::KEY_W-1:0]                        cls
);
	import akd_pkg::*;

	logic [THR_W-1:0] sample_ext;

	assign sample_ext = THR_W'(sample);

	// First threshold that the sample lies below wins; scan from the top down
	always_comb begin
		cls = NO_KEY;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (sample_ext < thr[i]) begin
				cls = KEY_W'(i + 1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/akd_state.sv
`timescale 1ns / 1ps
`default_nettype none

module akd_state (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire akd_pkg::cfg_t                   cfg,
	input  wire logic                            advance,
	input  wire logic                            op_s1,
	input  wire logic [akd_pkg::SAMPLE_BITS-1:0] sample_s1,
	input  wire logic [akd_pkg::TIME_W-1:0]      now_s1,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic      [akd_pkg::KEY_W-1:0]       key,
	output logic                                 key_valid,
	output akd_pkg::status_t                     status
);
	import akd_pkg::*;

	logic [SAMPLE_BITS-1:0] held_sample_q;
	logic [TIME_W-1:0]      change_time_q;
	logic [KEY_W-1:0]       last_class_q;
	logic [TIME_W-1:0]      press_time_q;
	logic [KEY_W-1:0]       pending_key_q;
	logic                   pending_flag_q;

	logic                   out_valid_q;
	logic [KEY_W-1:0]       key_q;
	logic                   key_valid_q;

	logic [TIME_W-1:0]      since_change;
	logic [TIME_W-1:0]      since_press;
	logic                   take_sample;
	logic [SAMPLE_BITS-1:0] held_next;
	logic [KEY_W-1:0]       cls;
	logic                   new_class;
	logic                   repeat_hit;
	logic [KEY_W-1:0]       pend_key_next;
	logic                   pend_flag_next;

	assign since_change = now_s1 - change_time_q;
	assign since_press  = now_s1 - press_time_q;
	assign take_sample  = (sample_s1 != held_sample_q) &&
	                      (since_change > TIME_W'(cfg.debounce_ms));
	assign held_next    = take_sample ? sample_s1 : held_sample_q;

	akd_classify u_classify (
		.sample (held_next),
		.thr    (cfg.thr),
		.cls    (cls)
	);

	assign new_class  = (cls != last_class_q);
	assign repeat_hit = !new_class && (last_class_q != NO_KEY) &&
	                    (since_press > TIME_W'(cfg.repeat_ms));

	always_comb begin
		pend_key_next  = pending_key_q;
		pend_flag_next = pending_flag_q;
		if ((new_class && cls != NO_KEY) || repeat_hit) begin
			pend_key_next  = cls;
			pend_flag_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_sample_q  <= '0;
			change_time_q  <= '0;
			last_class_q   <= NO_KEY;
			press_time_q   <= '0;
			pending_key_q  <= '0;
			pending_flag_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				if (op_s1 == OP_READ) begin
					pending_key_q  <= '0;
					pending_flag_q <= 1'b0;
				end else begin
					held_sample_q <= held_next;
					if (take_sample) begin
						change_time_q <= now_s1;
					end
					if (new_class) begin
						last_class_q <= cls;
						press_time_q <= now_s1;
					end
					pending_key_q  <= pend_key_next;
					pending_flag_q <= pend_flag_next;
				end
			end
		end
	end

	// Result payload: a read reports the value before clearing
	always_ff @(posedge clk) begin
		if (advance) begin
			if (op_s1 == OP_READ) begin
				key_q       <= pending_key_q;
				key_valid_q <= pending_flag_q;
			end else begin
				key_q       <= pend_key_next;
				key_valid_q <= pend_flag_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign key       = key_q;
	assign key_valid = key_valid_q;

	assign status.pending_flag = pending_flag_q;
	assign status.pending_key  = pending_key_q;
	assign status.last_class   = last_class_q;

endmodule

`default_nettype wire

FILE: rtl/analog_ladder_keypad_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                               Transaction
// ------    ------------------------------------  --------------------------------
// in        in_valid/in_ready, op, sample, now_ms  one tick or one read
// out       out_valid/out_ready, key, key_valid    one result per input transaction
// cfg       cfg_we, cfg_index, cfg_data            one register write, no wait
//
// One transaction is accepted per cycle while the result is not stalled; the input
// register takes it at the accepting edge, and when it advances the state update
// and the result register are written together, which presents the result.
// The throughput is set by the single state-update stage, which closes the
// debounce subtract, the threshold compare chain and the repeat check each cycle.
// Reset clears the decoder state and loads the default thresholds and timings.
// A stalled result holds in the output register; the input stage takes one more
// transaction, then in_ready drops until the result is taken.

module analog_ladder_keypad_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [akd_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic [akd_pkg::TIME_W-1:0]      now_ms,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [akd_pkg::KEY_W-1:0]       key,
	output logic                                 key_valid,
	input  wire logic                            cfg_we,
	input  wire logic [akd_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [akd_pkg::CFG_W-1:0]       cfg_data
);
	import akd_pkg::*;

	cfg_t    cfg;
	status_t status;

	// Input stage
	logic                   v_s1;
	logic                   op_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [TIME_W-1:0]      now_s1;
	logic                   advance;

	// Advance the held transaction when the result register is free or draining
	assign advance  = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Payload holds while the stage is stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1     <= op;
			sample_s1 <= sample;
			now_s1    <= now_ms;
		end
	end

	akd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	akd_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.op_s1     (op_s1),
		.sample_s1 (sample_s1),
		.now_s1    (now_s1),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.key       (key),
		.key_valid (key_valid),
		.status    (status)
	);

	// A result without a latched key must report key zero
	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !key_valid) |-> (key == '0))
		else $error("key nonzero without key_valid");

	// A latched key is always a real key number
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_valid) |-> (key != '0 && key <= KEY_W'(NUM_KEYS)))
		else $error("latched key out of range");

	// The pending key is dropped after a read transaction advances
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_READ) |=> (!status.pending_flag && status.pending_key == '0))
		else $error("pending key not cleared by read");

	// The last class is never the unused code zero
	a_class_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		status.last_class != '0)
		else $error("last class holds code zero");

endmodule

`default_nettype wire
